>>> rtl/agt_pkg.sv
// shared types, constants and arithmetic helpers for the gravity torque pipeline
`timescale 1ns / 1ps
package agt_pkg;

   // cordic step count
   localparam int TRIG_ITERATIONS = 18;

   // register indexes
   localparam logic [2:0] REG_MODEL_LOADED       = 3'd0;
   localparam logic [2:0] REG_UPPER_ARM_MASS     = 3'd1;
   localparam logic [2:0] REG_FOREARM_MASS       = 3'd2;
   localparam logic [2:0] REG_WRIST_MASS         = 3'd3;
   localparam logic [2:0] REG_UPPER_ARM_CENTROID = 3'd4;
   localparam logic [2:0] REG_FOREARM_CENTROID   = 3'd5;
   localparam logic [2:0] REG_UPPER_ARM_LENGTH   = 3'd6;
   localparam logic [2:0] REG_FOREARM_LENGTH     = 3'd7;

   // fixed point constants
   localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
   localparam logic signed [35:0] TWOPI_Q30  = 36'sd6746518852;
   localparam logic signed [35:0] HALFPI_Q30 = 36'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
   localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
   localparam logic signed [31:0] WRIST_LEVER_Q16 = 32'sd5243;
   localparam logic signed [20:0] GRAV_Q16   = 21'sd642908;
   localparam logic signed [37:0] TORQUE_MAX = 38'sd8388607;
   localparam logic signed [37:0] TORQUE_MIN = -38'sd8388608;

   localparam logic signed [33:0] ATAN_HEAD [10] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
      34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149
   };

   // stage map
   localparam int ST_PREP  = 0;
   localparam int ROT_A    = 1;
   localparam int ST_TRIG  = ROT_A + TRIG_ITERATIONS;
   localparam int ST_MUL1  = ST_TRIG + 1;
   localparam int ST_SQ    = ST_MUL1 + 1;
   localparam int SQRT_LO  = ST_SQ + 1;
   localparam int SQRT_N   = 31;
   localparam int ST_DSET  = SQRT_LO + SQRT_N;
   localparam int DIV_LO   = ST_DSET + 1;
   localparam int DIV_N    = 32;
   localparam int ST_ANG5  = DIV_LO + DIV_N;
   localparam int ROT_B    = ST_ANG5 + 1;
   localparam int ST_K     = ROT_B + TRIG_ITERATIONS;
   localparam int ST_SUM   = ST_K + 1;
   localparam int ST_MASS  = ST_SUM + 1;
   localparam int ST_J2    = ST_MASS + 1;
   localparam int ST_GRAV  = ST_J2 + 1;
   localparam int ST_SAT   = ST_GRAV + 1;
   localparam int NSTG     = ST_SAT + 1;

   // one cordic lane
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               flip;
   } rot_type;

   // everything a request carries down the pipe
   typedef struct packed {
      rot_type            ln1;
      rot_type            ln12;
      rot_type            ln3;
      rot_type            ln4;
      rot_type            ln5;
      rot_type            vec;
      logic signed [35:0] t12;
      logic signed [31:0] s1;
      logic signed [31:0] s12;
      logic signed [31:0] s3;
      logic signed [31:0] c3;
      logic signed [31:0] s4;
      logic signed [31:0] c4;
      logic signed [31:0] s;
      logic signed [31:0] num;
      logic signed [31:0] la;
      logic signed [31:0] lb;
      logic signed [31:0] lc;
      logic signed [31:0] ld;
      logic signed [31:0] l4;
      logic signed [31:0] k;
      logic signed [31:0] k3;
      logic signed [31:0] kk;
      logic [62:0]        sqv;
      logic [62:0]        sqr;
      logic [30:0]        den;
      logic [30:0]        rem;
      logic [31:0]        lo;
      logic [31:0]        quo;
      logic               ovf;
      logic               sing;
      logic signed [37:0] p1;
      logic signed [37:0] p2;
      logic signed [37:0] p3;
      logic signed [37:0] j3;
      logic signed [37:0] j4;
      logic signed [37:0] j5;
      logic signed [23:0] tq2;
      logic signed [23:0] tq3;
      logic signed [23:0] tq4;
      logic signed [23:0] tq5;
   } item_type;

   function automatic logic signed [33:0] atan_step(input int unsigned i);
      logic signed [33:0] a;
      if (i < 10) a = ATAN_HEAD[i[3:0]];
      else if (i <= 30) a = 34'((64'd1 << (30 - i)) - 64'd1);
      else a = '0;
      return a;
   endfunction

   // wrap into [-pi, pi) and fold into [-pi/2, pi/2]
   function automatic rot_type wrap_angle(input logic signed [35:0] ang);
      logic signed [35:0] r;
      rot_type o;
      r = ang;
      if (r >= TWOPI_Q30) r = r - TWOPI_Q30;
      else if (r <= -TWOPI_Q30) r = r + TWOPI_Q30;
      if (r >= PI_Q30) r = r - TWOPI_Q30;
      else if (r < -PI_Q30) r = r + TWOPI_Q30;
      o.flip = 1'b0;
      if (r > HALFPI_Q30) begin
         r = r - PI_Q30;
         o.flip = 1'b1;
      end else if (r < -HALFPI_Q30) begin
         r = r + PI_Q30;
         o.flip = 1'b1;
      end
      o.x = GAIN_Q30;
      o.y = '0;
      o.z = r[33:0];
      return o;
   endfunction

   function automatic rot_type rot_step(input rot_type l, input int unsigned i);
      rot_type o;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] a;
      o = l;
      dx = l.x >>> i;
      dy = l.y >>> i;
      a = atan_step(i);
      if (!l.z[33]) begin
         o.x = l.x - dy;
         o.y = l.y + dx;
         o.z = l.z - a;
      end else begin
         o.x = l.x + dy;
         o.y = l.y - dx;
         o.z = l.z + a;
      end
      return o;
   endfunction

   function automatic rot_type vec_step(input rot_type l, input int unsigned i);
      rot_type o;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] a;
      o = l;
      dx = l.x >>> i;
      dy = l.y >>> i;
      a = atan_step(i);
      if (l.y > 34'sd0) begin
         o.x = l.x + dy;
         o.y = l.y - dx;
         o.z = l.z + a;
      end else begin
         o.x = l.x - dy;
         o.y = l.y + dx;
         o.z = l.z - a;
      end
      return o;
   endfunction

   // undo the fold and clamp to one
   function automatic logic signed [31:0] rot_fin(input logic signed [33:0] v,
                                                 input logic flip);
      logic signed [33:0] w;
      logic signed [31:0] o;
      w = flip ? -v : v;
      if (w > 34'(ONE_Q30)) o = ONE_Q30;
      else if (w < -34'(ONE_Q30)) o = -ONE_Q30;
      else o = w[31:0];
      return o;
   endfunction

   // product scaled by 2^-30, rounded half away from zero
   function automatic logic signed [31:0] mq30(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [63:0] p;
      logic [63:0] m;
      logic signed [31:0] o;
      p = a * b;
      m = p[63] ? $unsigned(-p) : $unsigned(p);
      m = (m + (64'd1 << 29)) >> 30;
      o = m[31:0];
      return p[63] ? -o : o;
   endfunction

   // lever times mass
   function automatic logic signed [37:0] mulm(input logic signed [31:0] a,
                                              input logic [15:0] m);
      logic signed [48:0] p;
      p = a * $signed({1'b0, m});
      return p[37:0];
   endfunction

   // moment times g, scaled by 2^-32, rounded half away from zero
   function automatic logic signed [37:0] grav(input logic signed [37:0] v);
      logic signed [57:0] p;
      logic [57:0] m;
      logic signed [37:0] o;
      p = v * GRAV_Q16;
      m = p[57] ? $unsigned(-p) : $unsigned(p);
      m = (m + (58'd1 << 31)) >> 32;
      o = m[37:0];
      return p[57] ? -o : o;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
      logic signed [23:0] o;
      if (v > TORQUE_MAX) o = 24'sh7FFFFF;
      else if (v < TORQUE_MIN) o = 24'sh800000;
      else o = v[23:0];
      return o;
   endfunction

endpackage

>>> rtl/arm_gravity_torque.sv
// gravity compensation torques for joints 2 to 5, fully pipelined
`timescale 1ns / 1ps
// pipeline: agt_pkg::NSTG register stages from request to result (two cordic chains of
//   18 steps, a 31-step square root and a 32-step divider in series)
// throughput: one request per cycle; the whole pipe holds while a result waits
// reset: synchronous, clears the csr registers and all valid bits; no result until
//   model_loaded is written to 1
module arm_gravity_torque (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // angle_joint_two, angle_joint_three, angle_joint_four, angle_joint_five, pad
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // torque_joint_two, torque_joint_three, torque_joint_four, torque_joint_five
   output logic [95:0] rsp_tdata,
   // singular
   output logic [0:0]  rsp_tuser,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_wdata
);
   import agt_pkg::*;

   logic               model_loaded_ff;
   logic [15:0]        upper_arm_mass_ff;
   logic [15:0]        forearm_mass_ff;
   logic [15:0]        wrist_mass_ff;
   logic signed [17:0] upper_arm_centroid_ff;
   logic signed [17:0] forearm_centroid_ff;
   logic [16:0]        upper_arm_length_ff;
   logic [16:0]        forearm_length_ff;

   item_type pipe_ff [NSTG];
   item_type pipe_in [NSTG];
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic adv;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         model_loaded_ff       <= 1'b0;
         upper_arm_mass_ff     <= '0;
         forearm_mass_ff       <= '0;
         wrist_mass_ff         <= '0;
         upper_arm_centroid_ff <= '0;
         forearm_centroid_ff   <= '0;
         upper_arm_length_ff   <= '0;
         forearm_length_ff     <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_MODEL_LOADED:       model_loaded_ff       <= csr_wdata[0];
            REG_UPPER_ARM_MASS:     upper_arm_mass_ff     <= csr_wdata[15:0];
            REG_FOREARM_MASS:       forearm_mass_ff       <= csr_wdata[15:0];
            REG_WRIST_MASS:         wrist_mass_ff         <= csr_wdata[15:0];
            REG_UPPER_ARM_CENTROID: upper_arm_centroid_ff <= csr_wdata;
            REG_FOREARM_CENTROID:   forearm_centroid_ff   <= csr_wdata;
            REG_UPPER_ARM_LENGTH:   upper_arm_length_ff   <= csr_wdata[16:0];
            REG_FOREARM_LENGTH:     forearm_length_ff     <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // pipe moves whenever the output stage is free or being taken
   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid && model_loaded_ff};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv) pipe_ff <= pipe_in;
   end

   // link angles, wrapped and folded
   always_comb begin
      logic signed [35:0] a2;
      logic signed [35:0] a3;
      logic signed [35:0] a4;
      logic signed [35:0] a5;
      logic signed [35:0] t1;
      a2 = {{17{req_tdata[18]}}, req_tdata[18:0]};
      a3 = {{17{req_tdata[37]}}, req_tdata[37:19]};
      a4 = {{17{req_tdata[56]}}, req_tdata[56:38]};
      a5 = {{17{req_tdata[75]}}, req_tdata[75:57]};
      pipe_in[ST_PREP] = pipe_ff[ST_PREP];
      t1 = -(a2 <<< 14);
      pipe_in[ST_PREP].t12  = -((a2 + a3) <<< 14) + HALFPI_Q30;
      pipe_in[ST_PREP].ln1  = wrap_angle(t1);
      pipe_in[ST_PREP].ln12 = wrap_angle(-((a2 + a3) <<< 14) + HALFPI_Q30);
      pipe_in[ST_PREP].ln4  = wrap_angle(-(a4 <<< 14));
      pipe_in[ST_PREP].ln3  = wrap_angle(-(a5 <<< 14));
   end

   for (genvar k = 1; k < NSTG; k++) begin : g_stg
      if (k >= ROT_A && k < ROT_A + TRIG_ITERATIONS) begin : g_rot_a
         // four rotation lanes, one step each
         always_comb begin
            pipe_in[k]      = pipe_ff[k-1];
            pipe_in[k].ln1  = rot_step(pipe_ff[k-1].ln1, k - ROT_A);
            pipe_in[k].ln12 = rot_step(pipe_ff[k-1].ln12, k - ROT_A);
            pipe_in[k].ln3  = rot_step(pipe_ff[k-1].ln3, k - ROT_A);
            pipe_in[k].ln4  = rot_step(pipe_ff[k-1].ln4, k - ROT_A);
         end
      end else if (k == ST_TRIG) begin : g_trig
         always_comb begin
            pipe_in[k]     = pipe_ff[k-1];
            pipe_in[k].s1  = rot_fin(pipe_ff[k-1].ln1.y, pipe_ff[k-1].ln1.flip);
            pipe_in[k].s12 = rot_fin(pipe_ff[k-1].ln12.y, pipe_ff[k-1].ln12.flip);
            pipe_in[k].s3  = rot_fin(pipe_ff[k-1].ln3.y, pipe_ff[k-1].ln3.flip);
            pipe_in[k].c3  = rot_fin(pipe_ff[k-1].ln3.x, pipe_ff[k-1].ln3.flip);
            pipe_in[k].s4  = rot_fin(pipe_ff[k-1].ln4.y, pipe_ff[k-1].ln4.flip);
            pipe_in[k].c4  = rot_fin(pipe_ff[k-1].ln4.x, pipe_ff[k-1].ln4.flip);
         end
      end else if (k == ST_MUL1) begin : g_mul1
         // wrist sine, numerator and lever arms
         always_comb begin
            pipe_in[k]     = pipe_ff[k-1];
            pipe_in[k].s   = mq30(pipe_ff[k-1].s3, pipe_ff[k-1].c4);
            pipe_in[k].num = mq30(pipe_ff[k-1].c3, pipe_ff[k-1].c4);
            pipe_in[k].la  = mq30({15'b0, upper_arm_length_ff}, pipe_ff[k-1].s1);
            pipe_in[k].lb  = mq30({15'b0, forearm_length_ff}, pipe_ff[k-1].s12);
            pipe_in[k].lc  = mq30({{14{forearm_centroid_ff[17]}}, forearm_centroid_ff},
                                  pipe_ff[k-1].s12);
            pipe_in[k].ld  = mq30({{14{upper_arm_centroid_ff[17]}}, upper_arm_centroid_ff},
                                  pipe_ff[k-1].s1);
            pipe_in[k].l4  = mq30(WRIST_LEVER_Q16, pipe_ff[k-1].s3);
         end
      end else if (k == ST_SQ) begin : g_sq
         // square-root argument 1 - s^2
         always_comb begin
            logic [31:0] ms;
            logic [63:0] sq;
            pipe_in[k]    = pipe_ff[k-1];
            ms = pipe_ff[k-1].s[31] ? $unsigned(-pipe_ff[k-1].s) : $unsigned(pipe_ff[k-1].s);
            sq = ms * ms;
            pipe_in[k].sqv = (sq >= (64'd1 << 60)) ? '0 : 63'((64'd1 << 60) - sq);
            pipe_in[k].sqr = '0;
            pipe_in[k].l4  = mq30(pipe_ff[k-1].l4, pipe_ff[k-1].s4);
         end
      end else if (k >= SQRT_LO && k < SQRT_LO + SQRT_N) begin : g_sqrt
         // one result bit per stage
         always_comb begin
            logic [62:0] b;
            logic [62:0] t;
            pipe_in[k] = pipe_ff[k-1];
            b = 63'd1 << (60 - 2 * (k - SQRT_LO));
            t = pipe_ff[k-1].sqr + b;
            if (pipe_ff[k-1].sqv >= t) begin
               pipe_in[k].sqv = pipe_ff[k-1].sqv - t;
               pipe_in[k].sqr = (pipe_ff[k-1].sqr >> 1) + b;
            end else begin
               pipe_in[k].sqr = pipe_ff[k-1].sqr >> 1;
            end
         end
      end else if (k == ST_DSET) begin : g_dset
         // divider and vectoring setup
         always_comb begin
            logic [30:0] mn;
            pipe_in[k] = pipe_ff[k-1];
            mn = pipe_ff[k-1].num[31] ? 31'($unsigned(-pipe_ff[k-1].num))
                                      : pipe_ff[k-1].num[30:0];
            pipe_in[k].den  = pipe_ff[k-1].sqr[30:0];
            pipe_in[k].sing = (pipe_ff[k-1].sqr == '0);
            pipe_in[k].ovf  = ({2'b0, mn[30:2]} >= pipe_ff[k-1].sqr[30:0]);
            pipe_in[k].rem  = {2'b0, mn[30:2]};
            pipe_in[k].lo   = {mn[1:0], 30'b0};
            pipe_in[k].quo  = '0;
            pipe_in[k].vec.x = {3'b0, pipe_ff[k-1].sqr[30:0]};
            pipe_in[k].vec.y = {{2{pipe_ff[k-1].s[31]}}, pipe_ff[k-1].s};
            pipe_in[k].vec.z = '0;
            pipe_in[k].vec.flip = 1'b0;
            pipe_in[k].l4   = mq30(pipe_ff[k-1].l4, pipe_ff[k-1].s12);
         end
      end else if (k >= DIV_LO && k < DIV_LO + DIV_N) begin : g_div
         // restoring divide bit, arcsine step alongside
         always_comb begin
            logic [31:0] r2;
            pipe_in[k] = pipe_ff[k-1];
            r2 = {pipe_ff[k-1].rem, pipe_ff[k-1].lo[31]};
            pipe_in[k].lo = pipe_ff[k-1].lo << 1;
            if (r2 >= {1'b0, pipe_ff[k-1].den}) begin
               pipe_in[k].rem = 31'(r2 - {1'b0, pipe_ff[k-1].den});
               pipe_in[k].quo = {pipe_ff[k-1].quo[30:0], 1'b1};
            end else begin
               pipe_in[k].rem = r2[30:0];
               pipe_in[k].quo = {pipe_ff[k-1].quo[30:0], 1'b0};
            end
            if (k - DIV_LO < TRIG_ITERATIONS)
               pipe_in[k].vec = vec_step(pipe_ff[k-1].vec, k - DIV_LO);
         end
      end else if (k == ST_ANG5) begin : g_ang5
         // k3, arcsine and the wrist angle
         always_comb begin
            logic [31:0] q;
            logic signed [35:0] asn;
            pipe_in[k] = pipe_ff[k-1];
            if (pipe_ff[k-1].ovf || pipe_ff[k-1].quo > 32'(ONE_Q30)) q = ONE_Q30;
            else q = pipe_ff[k-1].quo;
            if (pipe_ff[k-1].sing) begin
               if (pipe_ff[k-1].num > 0) pipe_in[k].k3 = ONE_Q30;
               else if (pipe_ff[k-1].num < 0) pipe_in[k].k3 = -ONE_Q30;
               else pipe_in[k].k3 = '0;
               if (pipe_ff[k-1].s > 0) asn = HALFPI_Q30;
               else if (pipe_ff[k-1].s < 0) asn = -HALFPI_Q30;
               else asn = '0;
            end else begin
               pipe_in[k].k3 = pipe_ff[k-1].num[31] ? -$signed(q) : $signed(q);
               asn = {{2{pipe_ff[k-1].vec.z[33]}}, pipe_ff[k-1].vec.z};
            end
            pipe_in[k].ln5 = wrap_angle(pipe_ff[k-1].t12 + asn);
         end
      end else if (k >= ROT_B && k < ROT_B + TRIG_ITERATIONS) begin : g_rot_b
         always_comb begin
            pipe_in[k]     = pipe_ff[k-1];
            pipe_in[k].ln5 = rot_step(pipe_ff[k-1].ln5, k - ROT_B);
         end
      end else if (k == ST_K) begin : g_k
         always_comb begin
            pipe_in[k]   = pipe_ff[k-1];
            pipe_in[k].k = mq30(WRIST_LEVER_Q16,
                                rot_fin(pipe_ff[k-1].ln5.y, pipe_ff[k-1].ln5.flip));
         end
      end else if (k == ST_SUM) begin : g_sum
         // lever sums
         always_comb begin
            pipe_in[k]    = pipe_ff[k-1];
            pipe_in[k].kk = mq30(pipe_ff[k-1].k, pipe_ff[k-1].k3);
            pipe_in[k].la = -pipe_ff[k-1].la - pipe_ff[k-1].lc;
            pipe_in[k].lb = pipe_ff[k-1].la + pipe_ff[k-1].lb + pipe_ff[k-1].k;
            pipe_in[k].lc = pipe_ff[k-1].lc + pipe_ff[k-1].lb + pipe_ff[k-1].k;
         end
      end else if (k == ST_MASS) begin : g_mass
         always_comb begin
            pipe_in[k]    = pipe_ff[k-1];
            pipe_in[k].p1 = mulm(-pipe_ff[k-1].ld, upper_arm_mass_ff);
            pipe_in[k].p2 = mulm(pipe_ff[k-1].la, forearm_mass_ff);
            pipe_in[k].p3 = mulm(pipe_ff[k-1].lb, wrist_mass_ff);
            pipe_in[k].j3 = mulm(pipe_ff[k-1].lc, forearm_mass_ff);
            pipe_in[k].j4 = mulm(-pipe_ff[k-1].l4, wrist_mass_ff);
            pipe_in[k].j5 = mulm(pipe_ff[k-1].kk, wrist_mass_ff);
         end
      end else if (k == ST_J2) begin : g_j2
         always_comb begin
            pipe_in[k]    = pipe_ff[k-1];
            pipe_in[k].p1 = pipe_ff[k-1].p1 + pipe_ff[k-1].p2 - pipe_ff[k-1].p3;
         end
      end else if (k == ST_GRAV) begin : g_grav
         always_comb begin
            pipe_in[k]    = pipe_ff[k-1];
            pipe_in[k].p1 = grav(pipe_ff[k-1].p1);
            pipe_in[k].j3 = grav(pipe_ff[k-1].j3);
            pipe_in[k].j4 = grav(pipe_ff[k-1].j4);
            pipe_in[k].j5 = grav(pipe_ff[k-1].j5);
         end
      end else begin : g_sat
         // saturate into the output register
         always_comb begin
            pipe_in[k]     = pipe_ff[k-1];
            pipe_in[k].tq2 = sat24(pipe_ff[k-1].p1);
            pipe_in[k].tq3 = sat24(pipe_ff[k-1].j3);
            pipe_in[k].tq4 = sat24(pipe_ff[k-1].j4);
            pipe_in[k].tq5 = sat24(pipe_ff[k-1].j5);
         end
      end
   end

   // result channel
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {pipe_ff[NSTG-1].tq5, pipe_ff[NSTG-1].tq4,
                        pipe_ff[NSTG-1].tq3, pipe_ff[NSTG-1].tq2};
   assign rsp_tuser  = pipe_ff[NSTG-1].sing;

endmodule

>>> rtl/agt_checker.sv
// port-level checks for the gravity torque block, with its bind
`timescale 1ns / 1ps
module agt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // stalled output stalls the request side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while output stalled");

   // empty output never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // reset empties the pipe
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind arm_gravity_torque agt_checker u_agt_checker (.*);
